/* rtl/core/csmc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csmc_pkg: shared types and constants of the clock and stopwatch controller
// Holds the command record passed from the front to the back, display
// constants, reciprocal constants and the decimal split helper.
// ----------------------------------------------------------------------------
package csmc_pkg;

  localparam int QUEUE_DEPTH = 2;

  localparam logic [2:0] FUNC_REFRESH   = 3'd0;
  localparam logic [2:0] FUNC_VIEW      = 3'd1;
  localparam logic [2:0] FUNC_STOPWATCH = 3'd2;
  localparam logic [2:0] FUNC_SET_TIME  = 3'd3;
  localparam logic [2:0] FUNC_DECREASE  = 3'd4;
  localparam logic [2:0] FUNC_INCREASE  = 3'd5;

  localparam logic [3:0] BLANK = 4'd15;

  localparam int HOUR_MAX   = 23;
  localparam int MINUTE_MAX = 59;

  localparam int          TICKS_PER_SEC = 10000;
  localparam int          SIXTY         = 60;
  localparam int          CENTI_RECIP   = 5243;
  localparam int          CENTI_SHIFT   = 19;
  localparam logic [31:0] SEC_RECIP     = 32'hD1B7_1759;
  localparam int          SEC_SHIFT     = 45;
  localparam logic [19:0] MIN_RECIP     = 20'd559241;
  localparam int          MIN_SHIFT     = 25;

  typedef enum logic [1:0] {
    SW_VIEW_CENTI,
    SW_VIEW_SECONDS,
    SW_VIEW_HOURS
  } sw_view_t;

  typedef enum logic [2:0] {
    KIND_BLANK,
    KIND_PAIR,
    KIND_STOPWATCH,
    KIND_EDIT_HOURS,
    KIND_EDIT_MINUTES
  } show_kind_t;

  typedef struct packed {
    show_kind_t  kind;
    sw_view_t    sw_view;
    logic [5:0]  hi;
    logic [5:0]  lo;
    logic [31:0] ticks;
    logic        timer_start;
    logic        timer_stop;
    logic        timer_clear;
    logic        time_write;
    logic [4:0]  write_hours;
    logic [5:0]  write_minutes;
  } cmd_t;

  // Splits a value below 128 into tens and units, tens in the upper nibble.
  function automatic logic [7:0] split_decimal(input logic [6:0] value);
    logic [17:0] prod;
    logic [6:0]  tens;
    logic [6:0]  units;
    prod  = 18'(value) * 18'd205;
    tens  = 7'(prod >> 11);
    units = value - 7'(tens * 7'd10);
    return {tens[3:0], units[3:0]};
  endfunction

endpackage

/* rtl/core/csmc_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csmc_front: mode state and item classification
// Applies each accepted item to the mode state and pushes one display
// command, with its strobes and clock write, into the queue.
// ----------------------------------------------------------------------------
module csmc_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  output logic             item_ready,
  input  logic [2:0]       func,
  input  logic [4:0]       clock_hours,
  input  logic [5:0]       clock_minutes,
  input  logic [5:0]       clock_seconds,
  input  logic [31:0]      stopwatch_ticks,
  output logic             push_valid,
  input  logic             push_ready,
  output csmc_pkg::cmd_t   push_data
);
  import csmc_pkg::*;

  typedef enum logic [1:0] {
    MODE_CLOCK,
    MODE_STOPWATCH,
    MODE_SET
  } mode_t;

  typedef enum logic [1:0] {
    PH_STOPPED,
    PH_IDLE,
    PH_RUNNING
  } phase_t;

  mode_t      top_mode, top_mode_next;
  logic       clock_view, clock_view_next;
  sw_view_t   stopwatch_view, stopwatch_view_next;
  logic       edit_view, edit_view_next;
  phase_t     stopwatch_phase, stopwatch_phase_next;
  logic [4:0] edit_hours, edit_hours_next;
  logic [5:0] edit_minutes, edit_minutes_next;
  logic [5:0] hours_inc;
  logic [6:0] minutes_inc;
  logic       accept;
  cmd_t       cmd;

  assign item_ready = push_ready;
  assign push_valid = item_valid;
  assign accept     = item_valid && push_ready;
  assign push_data  = cmd;
  assign hours_inc   = {1'b0, edit_hours} + 6'd1;
  assign minutes_inc = {1'b0, edit_minutes} + 7'd1;

  always_comb begin
    top_mode_next        = top_mode;
    clock_view_next      = clock_view;
    stopwatch_view_next  = stopwatch_view;
    edit_view_next       = edit_view;
    stopwatch_phase_next = stopwatch_phase;
    edit_hours_next      = edit_hours;
    edit_minutes_next    = edit_minutes;
    cmd                  = '0;
    cmd.ticks            = stopwatch_ticks;

    case (func)
      FUNC_VIEW: begin
        case (top_mode)
          MODE_CLOCK: clock_view_next = ~clock_view;
          MODE_STOPWATCH: begin
            case (stopwatch_view)
              SW_VIEW_CENTI:   stopwatch_view_next = SW_VIEW_SECONDS;
              SW_VIEW_SECONDS: stopwatch_view_next = SW_VIEW_HOURS;
              SW_VIEW_HOURS:   stopwatch_view_next = SW_VIEW_CENTI;
              default: ;
            endcase
          end
          MODE_SET: edit_view_next = ~edit_view;
          default: ;
        endcase
      end
      FUNC_STOPWATCH: begin
        case (top_mode)
          MODE_CLOCK: begin
            top_mode_next        = MODE_STOPWATCH;
            stopwatch_phase_next = PH_IDLE;
          end
          MODE_STOPWATCH: begin
            case (stopwatch_phase)
              PH_IDLE: begin
                cmd.timer_start      = 1'b1;
                stopwatch_phase_next = PH_RUNNING;
                stopwatch_view_next  = SW_VIEW_CENTI;
              end
              PH_RUNNING: begin
                cmd.timer_stop       = 1'b1;
                stopwatch_phase_next = PH_STOPPED;
              end
              PH_STOPPED: begin
                cmd.timer_clear = 1'b1;
                top_mode_next   = MODE_CLOCK;
              end
              default: ;
            endcase
          end
          default: ;
        endcase
      end
      FUNC_SET_TIME: begin
        case (top_mode)
          MODE_CLOCK: begin
            top_mode_next     = MODE_SET;
            edit_hours_next   = clock_hours;
            edit_minutes_next = clock_minutes;
          end
          MODE_SET: begin
            top_mode_next     = MODE_CLOCK;
            cmd.time_write    = 1'b1;
            cmd.write_hours   = edit_hours;
            cmd.write_minutes = edit_minutes;
          end
          default: ;
        endcase
      end
      FUNC_DECREASE: begin
        if (top_mode == MODE_SET) begin
          if (!edit_view) begin
            edit_hours_next = (edit_hours == '0) ? 5'(HOUR_MAX) : edit_hours - 5'd1;
          end else begin
            edit_minutes_next = (edit_minutes == '0) ? 6'(MINUTE_MAX)
                                                     : edit_minutes - 6'd1;
          end
        end
      end
      FUNC_INCREASE: begin
        if (top_mode == MODE_SET) begin
          if (!edit_view) begin
            edit_hours_next = (hours_inc > 6'(HOUR_MAX)) ? '0 : hours_inc[4:0];
          end else begin
            edit_minutes_next = (minutes_inc > 7'(MINUTE_MAX)) ? '0 : minutes_inc[5:0];
          end
        end
      end
      default: ;
    endcase

    cmd.sw_view = stopwatch_view_next;
    case (top_mode_next)
      MODE_CLOCK: begin
        cmd.kind = KIND_PAIR;
        cmd.hi   = clock_view_next ? clock_minutes : {1'b0, clock_hours};
        cmd.lo   = clock_view_next ? clock_seconds : clock_minutes;
      end
      MODE_STOPWATCH: begin
        cmd.kind = (stopwatch_view_next == SW_VIEW_CENTI ||
                    stopwatch_view_next == SW_VIEW_SECONDS ||
                    stopwatch_view_next == SW_VIEW_HOURS) ? KIND_STOPWATCH : KIND_BLANK;
      end
      MODE_SET: begin
        cmd.kind = edit_view_next ? KIND_EDIT_MINUTES : KIND_EDIT_HOURS;
        cmd.hi   = {1'b0, edit_hours_next};
        cmd.lo   = edit_minutes_next;
      end
      default: cmd.kind = KIND_BLANK;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      top_mode        <= MODE_CLOCK;
      clock_view      <= 1'b0;
      stopwatch_view  <= SW_VIEW_CENTI;
      edit_view       <= 1'b0;
      stopwatch_phase <= PH_STOPPED;
    end else if (accept) begin
      top_mode        <= top_mode_next;
      clock_view      <= clock_view_next;
      stopwatch_view  <= stopwatch_view_next;
      edit_view       <= edit_view_next;
      stopwatch_phase <= stopwatch_phase_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      edit_hours   <= edit_hours_next;
      edit_minutes <= edit_minutes_next;
    end
  end

endmodule

/* rtl/core/csmc_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csmc_queue: command queue between front and back
// A small register queue that lets the front accept items while the back
// is busy converting a stopwatch count.
// ----------------------------------------------------------------------------
module csmc_queue #(
  parameter int DEPTH = csmc_pkg::QUEUE_DEPTH
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push_valid,
  output logic           push_ready,
  input  csmc_pkg::cmd_t push_data,
  output logic           pop_valid,
  input  logic           pop_ready,
  output csmc_pkg::cmd_t pop_data
);
  import csmc_pkg::*;

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  cmd_t             slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             push_fire;
  logic             pop_fire;

  assign push_ready = (count != CNT_W'(DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_data   = slots[rd_ptr];
  assign push_fire  = push_valid && push_ready;
  assign pop_fire   = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (push_fire) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push_fire) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop_fire) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push_fire && !pop_fire) begin
        count <= count + CNT_W'(1);
      end else if (pop_fire && !push_fire) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

/* rtl/core/csmc_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csmc_back: display conversion and result register
// Takes one command at a time, converts a stopwatch count to centiseconds,
// seconds, minutes and hours by reciprocal multiplication in the states
// ST_SEC, ST_CENTI, ST_MIN and ST_HOUR, and forms the four digits.
// ----------------------------------------------------------------------------
module csmc_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           pop_valid,
  output logic           pop_ready,
  input  csmc_pkg::cmd_t pop_data,
  output logic           result_valid,
  input  logic           result_ready,
  output logic [3:0]     digit_a,
  output logic [3:0]     digit_b,
  output logic [3:0]     digit_c,
  output logic [3:0]     digit_d,
  output logic           timer_start,
  output logic           timer_stop,
  output logic           timer_clear,
  output logic           time_write,
  output logic [4:0]     write_hours,
  output logic [5:0]     write_minutes
);
  import csmc_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEC,
    ST_CENTI,
    ST_MIN,
    ST_HOUR,
    ST_EMIT
  } state_t;

  state_t      state;
  cmd_t        cur;
  logic [18:0] tsec;
  logic [12:0] tmin;
  logic [13:0] sub_sec;
  logic [6:0]  centi;
  logic [5:0]  secs;
  logic [5:0]  mins;
  logic [6:0]  hours;
  logic [63:0] sec_prod;
  logic [18:0] div60_in;
  logic [38:0] div60_prod;
  logic [13:0] sec_back;
  logic [26:0] centi_prod;
  logic [15:0] digits;

  assign pop_ready  = (state == ST_IDLE);
  assign sec_prod   = {32'b0, cur.ticks} * {32'b0, SEC_RECIP};
  assign div60_in   = (state == ST_CENTI) ? tsec : {6'b0, tmin};
  assign div60_prod = {20'b0, div60_in} * {19'b0, MIN_RECIP};
  assign sec_back   = tsec[13:0] * 14'(TICKS_PER_SEC);
  assign centi_prod = 27'(sub_sec) * 27'(CENTI_RECIP);

  always_comb begin
    digits = {BLANK, BLANK, BLANK, BLANK};
    case (cur.kind)
      KIND_PAIR: digits = {split_decimal({1'b0, cur.hi}), split_decimal({1'b0, cur.lo})};
      KIND_EDIT_HOURS: digits = {split_decimal({1'b0, cur.hi}), BLANK, BLANK};
      KIND_EDIT_MINUTES: digits = {BLANK, BLANK, split_decimal({1'b0, cur.lo})};
      KIND_STOPWATCH: begin
        case (cur.sw_view)
          SW_VIEW_CENTI:   digits = {split_decimal({1'b0, secs}), split_decimal(centi)};
          SW_VIEW_SECONDS: digits = {split_decimal({1'b0, mins}),
                                     split_decimal({1'b0, secs})};
          SW_VIEW_HOURS:   digits = {split_decimal(hours), split_decimal({1'b0, mins})};
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      result_valid <= 1'b0;
    end else begin
      if (result_ready) begin
        result_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (pop_valid) begin
            cur   <= pop_data;
            state <= (pop_data.kind == KIND_STOPWATCH) ? ST_SEC : ST_EMIT;
          end
        end
        ST_SEC: begin
          tsec  <= 19'(sec_prod >> SEC_SHIFT);
          state <= ST_CENTI;
        end
        ST_CENTI: begin
          sub_sec <= cur.ticks[13:0] - sec_back;
          tmin    <= 13'(div60_prod >> MIN_SHIFT);
          state   <= ST_MIN;
        end
        ST_MIN: begin
          centi <= 7'(centi_prod >> CENTI_SHIFT);
          secs  <= tsec[5:0] - tmin[5:0] * 6'(SIXTY);
          hours <= 7'(div60_prod >> MIN_SHIFT);
          state <= ST_HOUR;
        end
        ST_HOUR: begin
          mins  <= tmin[5:0] - hours[5:0] * 6'(SIXTY);
          state <= ST_EMIT;
        end
        ST_EMIT: begin
          if (!result_valid || result_ready) begin
            result_valid  <= 1'b1;
            digit_a       <= digits[15:12];
            digit_b       <= digits[11:8];
            digit_c       <= digits[7:4];
            digit_d       <= digits[3:0];
            timer_start   <= cur.timer_start;
            timer_stop    <= cur.timer_stop;
            timer_clear   <= cur.timer_clear;
            time_write    <= cur.time_write;
            write_hours   <= cur.write_hours;
            write_minutes <= cur.write_minutes;
            state         <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

/* rtl/core/clock_stopwatch_mode_controller.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clock_stopwatch_mode_controller: mode controller of a four-digit clock
// Front applies refreshes and button presses to the mode state, a queue
// holds the display commands, and the back forms digits and strobes.
// ----------------------------------------------------------------------------
// The front takes one item per cycle while the command queue has room. For a
// clock, set-time or blank display the back goes from ST_IDLE straight to
// ST_EMIT; a stopwatch display first passes the states ST_SEC, ST_CENTI,
// ST_MIN and ST_HOUR, whose reciprocal multiplications split the count by
// 10000, 100 and twice by 60. A finished result that waits in the output
// register holds the back; the front goes on accepting until both queue
// slots are full and then drops item_ready.
module clock_stopwatch_mode_controller #(
  parameter int QUEUE_DEPTH = csmc_pkg::QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  output logic        item_ready,
  input  logic [2:0]  func,
  input  logic [4:0]  clock_hours,
  input  logic [5:0]  clock_minutes,
  input  logic [5:0]  clock_seconds,
  input  logic [31:0] stopwatch_ticks,
  output logic        result_valid,
  input  logic        result_ready,
  output logic [3:0]  digit_a,
  output logic [3:0]  digit_b,
  output logic [3:0]  digit_c,
  output logic [3:0]  digit_d,
  output logic        timer_start,
  output logic        timer_stop,
  output logic        timer_clear,
  output logic        time_write,
  output logic [4:0]  write_hours,
  output logic [5:0]  write_minutes
);
  import csmc_pkg::*;

  logic push_valid;
  logic push_ready;
  cmd_t push_data;
  logic pop_valid;
  logic pop_ready;
  cmd_t pop_data;

  csmc_front u_front (
    .clk             (clk),
    .rst             (rst),
    .item_valid      (item_valid),
    .item_ready      (item_ready),
    .func            (func),
    .clock_hours     (clock_hours),
    .clock_minutes   (clock_minutes),
    .clock_seconds   (clock_seconds),
    .stopwatch_ticks (stopwatch_ticks),
    .push_valid      (push_valid),
    .push_ready      (push_ready),
    .push_data       (push_data)
  );

  csmc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  csmc_back u_back (
    .clk           (clk),
    .rst           (rst),
    .pop_valid     (pop_valid),
    .pop_ready     (pop_ready),
    .pop_data      (pop_data),
    .result_valid  (result_valid),
    .result_ready  (result_ready),
    .digit_a       (digit_a),
    .digit_b       (digit_b),
    .digit_c       (digit_c),
    .digit_d       (digit_d),
    .timer_start   (timer_start),
    .timer_stop    (timer_stop),
    .timer_clear   (timer_clear),
    .time_write    (time_write),
    .write_hours   (write_hours),
    .write_minutes (write_minutes)
  );

  a_single_strobe: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> $onehot0({timer_start, timer_stop, timer_clear, time_write}))
    else $error("More than one timer or clock strobe in one item.");

  a_write_fields_idle: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !time_write) |-> (write_hours == '0 && write_minutes == '0))
    else $error("Clock write fields set without a clock write.");

  a_start_view: assert property (@(posedge clk) disable iff (rst)
    (result_valid && timer_start) |-> (digit_a <= 4'd5 && digit_c <= 4'd9))
    else $error("Stopwatch start did not show seconds and centiseconds.");

endmodule
